FILE: design/deq_pkg.sv
// shared types and codes for the double-ended queue
`timescale 1ns / 1ps

package deq_pkg;

    // default ring depth
    localparam int DEQ_DEPTH = 16;

    // command codes
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_DUMP       = 3'd4;

    // status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // command word
    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] value;
    } t_deq_in;

    // result word
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] element;
        logic               last;
    } t_deq_out;

endpackage

FILE: design/deq_ram.sv
// generic single-clock ram, one write port and one registered read port
`timescale 1ns / 1ps

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/double_ended_queue_unit.sv
// Double-ended queue of signed 32-bit words kept in a ring memory. A command word is
// taken when i_start is high and o_busy is low. Push front, push back, pop front and
// pop back each give one result word, strobed by o_res_valid for one cycle in the cycle
// after acceptance; o_busy stays low for them, so one command can be taken every cycle.
// A dump of N stored words gives N result words on consecutive cycles, front to back,
// the final one marked by last; for N above one, o_busy rises after acceptance and
// stays high until the read of the final word is issued, since each stored word goes
// through the single read port of the ring memory. Pop, push and dump on an empty or
// full queue answer with one status word. Unused command codes are dropped without a
// result. The receiver cannot stall: a result word is present for exactly one cycle.
`timescale 1ns / 1ps

module double_ended_queue_unit #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  deq_pkg::t_deq_in i_item,
    output logic             o_busy,
    output logic             o_res_valid,
    output deq_pkg::t_deq_out o_res
);

    import deq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] CNT_FULL  = CW'(DEPTH);
    localparam logic [CW:0]   DEPTH_EXT = (CW + 1)'(DEPTH);
    localparam logic [AW-1:0] IDX_LAST  = AW'(DEPTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DUMP = 2'b10
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_off,   n_off;
    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_status,    n_status;
    logic          r_last,      n_last;
    logic          r_use_rd,    n_use_rd;

    logic          accept;
    logic          is_full;
    logic          is_empty;
    logic [AW-1:0] front_dec;
    logic [AW-1:0] front_inc;
    logic [CW-1:0] count_dec;
    logic [CW-1:0] off_inc;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data;

    // ring position of front plus an offset below the depth
    function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW + 1)'(base) + (CW + 1)'(off);
        if (sum >= DEPTH_EXT) begin
            sum = sum - DEPTH_EXT;
        end
        return sum[AW-1:0];
    endfunction

    assign accept    = i_start && (r_state == ST_IDLE);
    assign is_full   = (r_count == CNT_FULL);
    assign is_empty  = (r_count == '0);
    assign front_dec = (r_front == '0) ? IDX_LAST : r_front - AW'(1);
    assign front_inc = (r_front == IDX_LAST) ? '0 : r_front + AW'(1);
    assign count_dec = r_count - CW'(1);
    assign off_inc   = r_off + CW'(1);

    // command decode and dump sequencing
    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_count     = r_count;
        n_off       = r_off;
        n_out_valid = 1'b0;
        n_status    = STAT_OK;
        n_last      = 1'b1;
        n_use_rd    = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_item.command)
                        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                            n_out_valid = 1'b1;
                            if (is_full) begin
                                n_status = STAT_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + CW'(1);
                                if (i_item.command == CMD_PUSH_FRONT) begin
                                    wr_addr = front_dec;
                                    n_front = front_dec;
                                end else begin
                                    wr_addr = ring_pos(r_front, r_count);
                                end
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK: begin
                            n_out_valid = 1'b1;
                            if (is_empty) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                rd_en    = 1'b1;
                                n_use_rd = 1'b1;
                                n_count  = count_dec;
                                if (i_item.command == CMD_POP_FRONT) begin
                                    rd_addr = r_front;
                                    n_front = front_inc;
                                end else begin
                                    rd_addr = ring_pos(r_front, count_dec);
                                end
                            end
                        end
                        CMD_DUMP: begin
                            n_out_valid = 1'b1;
                            if (is_empty) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                rd_en    = 1'b1;
                                rd_addr  = r_front;
                                n_use_rd = 1'b1;
                                n_last   = (r_count == CW'(1));
                                n_off    = CW'(1);
                                if (r_count != CW'(1)) begin
                                    n_state = ST_DUMP;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DUMP: begin
                rd_en       = 1'b1;
                rd_addr     = ring_pos(r_front, r_off);
                n_out_valid = 1'b1;
                n_use_rd    = 1'b1;
                n_last      = (off_inc == r_count);
                n_off       = off_inc;
                if (off_inc == r_count) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_off       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_off       <= n_off;
            r_out_valid <= n_out_valid;
        end
    end

    // result word fields
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_last   <= n_last;
        r_use_rd <= n_use_rd;
    end

    // ring memory
    deq_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_item.value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // outputs
    assign o_busy        = (r_state != ST_IDLE);
    assign o_res_valid   = r_out_valid;
    assign o_res.status  = r_status;
    assign o_res.element = r_use_rd ? rd_data : '0;
    assign o_res.last    = r_last;

`ifndef SYNTHESIS
    // occupancy never exceeds the ring
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("entry count beyond depth");

    // dump offset stays inside the live entries
    a_dump_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DUMP) |-> (r_off < r_count) && (r_off != '0))
        else $error("dump offset out of range");

    // every dump cycle yields a result word next cycle
    a_dump_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DUMP) |=> o_res_valid)
        else $error("dump result word missing");

    // push and pop always answer in the next cycle
    a_cmd_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_item.command == CMD_PUSH_FRONT || i_item.command == CMD_PUSH_BACK
            || i_item.command == CMD_POP_FRONT || i_item.command == CMD_POP_BACK))
        |=> (o_res_valid && o_res.last))
        else $error("push or pop result word missing");
`endif

endmodule
